/* hdl/gbn_arq_pkg.sv */
package gbn_arq_pkg;

    // Fixed field widths of the link interface.
    localparam int DATA_WIDTH       = 32;
    localparam int SEQ_MODULUS      = 8;
    localparam int SEQ_W            = $clog2(SEQ_MODULUS);
    localparam int ADDR_W           = 8;
    localparam int CMD_W            = 2;
    localparam int FKIND_W          = 2;
    localparam int OKIND_W          = 3;
    localparam int WIN_W            = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;
    localparam int BUFFER_DEPTH_DEF = 16;

    // Event codes.
    localparam logic [CMD_W-1:0] CMD_APP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMER = 2'd2;

    // Received frame kinds.
    localparam logic [FKIND_W-1:0] FK_INFO = 2'd0;
    localparam logic [FKIND_W-1:0] FK_RR   = 2'd1;
    localparam logic [FKIND_W-1:0] FK_REJ  = 2'd2;

    // Result kinds.
    localparam logic [OKIND_W-1:0] OK_INFO    = 3'd0;
    localparam logic [OKIND_W-1:0] OK_RR      = 3'd1;
    localparam logic [OKIND_W-1:0] OK_REJ     = 3'd2;
    localparam logic [OKIND_W-1:0] OK_DELIVER = 3'd3;
    localparam logic [OKIND_W-1:0] OK_DROP    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [SEQ_W-1:0]      t_seq;
    typedef logic [ADDR_W-1:0]     t_addr;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        t_data              payload;
        logic [FKIND_W-1:0] frame_kind;
        t_seq               frame_seq;
        t_addr              frame_dest;
        logic               poll_bit;
        logic               bad_frame;
    } t_in_item;

    typedef struct packed {
        logic [OKIND_W-1:0] out_kind;
        t_seq               out_seq;
        t_addr              out_dest;
        t_data              out_data;
        logic               restart_timer;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DELIV,
        ST_ACK,
        ST_ACK_APPLY,
        ST_WIN,
        ST_SEND,
        ST_FLUSH
    } t_state;

endpackage

/* hdl/go_back_n_arq_link.sv */
// Channel   Direction  Handshake              Payload
// input     in         i_in_valid/o_in_stall    i_in  (gbn_arq_pkg::t_in_item)
// result    out        o_out_valid/i_out_stall  o_out (gbn_arq_pkg::t_out_item)
// config    in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One event is taken at a time, in an idle cycle. An application word is stored, or
// dropped when the store is full, and sends at most one INFO frame; a received INFO
// is answered with an RR and delivered, answered with a REJ unless one is pending,
// or discarded. An acknowledgement is range checked and may be refused; otherwise it,
// like a timer expiry, sends INFO frames while the window is open, each one pass of
// the shared sequence subtractor followed by one read of the retransmit memory.
// Reset is synchronous and clears all control state; the retransmit memory is
// not cleared, as an entry is only ever read after it has been written.
// A stall on the result channel holds the sequencer wherever a further result
// would have to leave the holding register, and the input stays stalled until
// the last result of the event has moved into the output register.
module go_back_n_arq_link #(
    parameter int BUFFER_DEPTH = gbn_arq_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    output logic                                         o_in_stall,
    input  gbn_arq_pkg::t_in_item                        i_in,
    output logic                                         o_out_valid,
    input  logic                                         i_out_stall,
    output gbn_arq_pkg::t_out_item                       o_out,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [gbn_arq_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [gbn_arq_pkg::CFG_DATA_W-1:0]            i_cfg_data
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int SEQ_W = gbn_arq_pkg::SEQ_W;
    localparam int WIN_W = gbn_arq_pkg::WIN_W;
    localparam int CMP_W = (CNT_W > SEQ_W) ? CNT_W : SEQ_W;

    // Configuration registers.
    gbn_arq_pkg::t_addr  r_own_addr;
    gbn_arq_pkg::t_addr  r_peer_addr;
    logic [WIN_W-1:0]    r_window;

    // Protocol state.
    gbn_arq_pkg::t_state r_state, n_state;
    gbn_arq_pkg::t_seq   r_unacked, n_unacked;
    gbn_arq_pkg::t_seq   r_next, n_next;
    gbn_arq_pkg::t_seq   r_expected, n_expected;
    logic                r_rej_pend, n_rej_pend;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_single, n_single;
    gbn_arq_pkg::t_seq   r_acked, n_acked;
    gbn_arq_pkg::t_in_item r_in;

    // Holding register for the newest result and the output register.
    logic                   r_hold_valid, n_hold_valid;
    gbn_arq_pkg::t_out_item r_hold, n_hold;
    logic                   r_out_valid;
    gbn_arq_pkg::t_out_item r_out;

    // Sequencer control and datapath.
    logic                in_accept;
    logic                slot_free;
    logic                push_ok;
    logic                push;
    logic                push_last;
    logic                discard;
    logic                too_far;
    logic                past_send;
    logic                win_open;
    gbn_arq_pkg::t_seq   alu_a;
    gbn_arq_pkg::t_seq   alu_b;
    gbn_arq_pkg::t_seq   alu_diff;
    logic [WIN_W-1:0]    win_cap;
    logic [CNT_W-1:0]    acked_cnt;
    logic [SUM_W-1:0]    head_sum;
    logic                buf_wr;
    logic                buf_rd;
    logic [CNT_W-1:0]    buf_rd_off;
    gbn_arq_pkg::t_data  buf_rd_data;

    function automatic gbn_arq_pkg::t_out_item make_result(
        input logic [gbn_arq_pkg::OKIND_W-1:0] kind,
        input gbn_arq_pkg::t_seq               seq,
        input gbn_arq_pkg::t_addr              dest,
        input gbn_arq_pkg::t_data              data,
        input logic                            timer);
        gbn_arq_pkg::t_out_item item;
        item.out_kind      = kind;
        item.out_seq       = seq;
        item.out_dest      = dest;
        item.out_data      = data;
        item.restart_timer = timer;
        item.last          = 1'b0;
        return item;
    endfunction

    function automatic gbn_arq_pkg::t_seq seq_inc(input gbn_arq_pkg::t_seq s);
        return (s == SEQ_W'(gbn_arq_pkg::SEQ_MODULUS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != gbn_arq_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The output register can take a result when it is empty or being drained.
    assign slot_free = !r_out_valid || !i_out_stall;
    assign push_ok   = !r_hold_valid || slot_free;

    // The single shared sequence subtractor. The modulus is a power of two,
    // so the wrap of the difference is the natural overflow of the field.
    assign alu_a    = (r_state == gbn_arq_pkg::ST_ACK) ? r_in.frame_seq : r_next;
    assign alu_b    = r_unacked;
    assign alu_diff = alu_a - alu_b;

    assign win_cap = (r_window > WIN_W'(gbn_arq_pkg::SEQ_MODULUS - 1))
                   ? WIN_W'(gbn_arq_pkg::SEQ_MODULUS - 1) : r_window;
    assign win_open = (alu_diff < SEQ_W'(win_cap))
                   && (CMP_W'(alu_diff) < CMP_W'(r_count));

    assign discard = r_in.poll_bit || r_in.bad_frame || (r_in.frame_dest != r_own_addr);
    assign too_far = CMP_W'(r_acked) > CMP_W'(r_count);
    assign past_send = r_acked > alu_diff;

    // The acknowledged count is at most the fill count once the range check passes.
    assign acked_cnt = CNT_W'(CMP_W'(r_acked));
    assign head_sum  = SUM_W'(r_head) + SUM_W'(acked_cnt);
    assign buf_rd_off = CNT_W'(CMP_W'(alu_diff));

    gbn_arq_rtx_buf #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_rtx_buf (
        .i_clk     (i_clk),
        .i_base    (r_head),
        .i_wr_en   (buf_wr),
        .i_wr_off  (r_count),
        .i_wr_data (r_in.payload),
        .i_rd_en   (buf_rd),
        .i_rd_off  (buf_rd_off),
        .o_rd_data (buf_rd_data)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbn_arq_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = gbn_arq_pkg::ST_EVAL;
                end
            end
            gbn_arq_pkg::ST_EVAL: begin
                priority case (r_in.cmd)
                    gbn_arq_pkg::CMD_APP:   n_state = gbn_arq_pkg::ST_WIN;
                    gbn_arq_pkg::CMD_TIMER: n_state = gbn_arq_pkg::ST_WIN;
                    gbn_arq_pkg::CMD_FRAME: begin
                        if (discard) begin
                            n_state = gbn_arq_pkg::ST_FLUSH;
                        end else if (r_in.frame_kind == gbn_arq_pkg::FK_INFO) begin
                            n_state = (r_in.frame_seq == r_expected)
                                    ? gbn_arq_pkg::ST_DELIV : gbn_arq_pkg::ST_FLUSH;
                        end else if (r_in.frame_kind == gbn_arq_pkg::FK_RR
                                  || r_in.frame_kind == gbn_arq_pkg::FK_REJ) begin
                            n_state = gbn_arq_pkg::ST_ACK;
                        end else begin
                            n_state = gbn_arq_pkg::ST_FLUSH;
                        end
                    end
                    default: n_state = gbn_arq_pkg::ST_FLUSH;
                endcase
            end
            gbn_arq_pkg::ST_DELIV: begin
                if (push_ok) begin
                    n_state = gbn_arq_pkg::ST_FLUSH;
                end
            end
            gbn_arq_pkg::ST_ACK: n_state = gbn_arq_pkg::ST_ACK_APPLY;
            gbn_arq_pkg::ST_ACK_APPLY: begin
                n_state = too_far ? gbn_arq_pkg::ST_FLUSH : gbn_arq_pkg::ST_WIN;
            end
            gbn_arq_pkg::ST_WIN: begin
                n_state = win_open ? gbn_arq_pkg::ST_SEND : gbn_arq_pkg::ST_FLUSH;
            end
            gbn_arq_pkg::ST_SEND: begin
                if (push_ok) begin
                    n_state = r_single ? gbn_arq_pkg::ST_FLUSH : gbn_arq_pkg::ST_WIN;
                end
            end
            gbn_arq_pkg::ST_FLUSH: begin
                if (!r_hold_valid || slot_free) begin
                    n_state = gbn_arq_pkg::ST_IDLE;
                end
            end
            default: n_state = gbn_arq_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and next values of the protocol state.
    always_comb begin
        n_unacked    = r_unacked;
        n_next       = r_next;
        n_expected   = r_expected;
        n_rej_pend   = r_rej_pend;
        n_head       = r_head;
        n_count      = r_count;
        n_single     = r_single;
        n_acked      = r_acked;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        push         = 1'b0;
        push_last    = 1'b0;
        buf_wr       = 1'b0;
        buf_rd       = 1'b0;
        unique case (r_state)
            gbn_arq_pkg::ST_EVAL: begin
                priority case (r_in.cmd)
                    gbn_arq_pkg::CMD_APP: begin
                        n_single = 1'b1;
                        if (r_count < CNT_W'(BUFFER_DEPTH)) begin
                            buf_wr  = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_hold_valid = 1'b1;
                            n_hold = make_result(gbn_arq_pkg::OK_DROP, '0, '0,
                                                 r_in.payload, 1'b0);
                        end
                    end
                    gbn_arq_pkg::CMD_FRAME: begin
                        n_single = 1'b0;
                        if (!discard && r_in.frame_kind == gbn_arq_pkg::FK_INFO) begin
                            if (r_in.frame_seq != r_expected) begin
                                if (!r_rej_pend) begin
                                    n_rej_pend   = 1'b1;
                                    n_hold_valid = 1'b1;
                                    n_hold = make_result(gbn_arq_pkg::OK_REJ, r_expected,
                                                         r_peer_addr, '0, 1'b0);
                                end
                            end else begin
                                n_expected   = seq_inc(r_expected);
                                n_rej_pend   = 1'b0;
                                n_hold_valid = 1'b1;
                                n_hold = make_result(gbn_arq_pkg::OK_RR,
                                                     seq_inc(r_expected),
                                                     r_peer_addr, '0, 1'b0);
                            end
                        end
                    end
                    gbn_arq_pkg::CMD_TIMER: begin
                        n_single = 1'b0;
                        n_next   = r_unacked;
                    end
                    default: begin
                        n_single = 1'b0;
                    end
                endcase
            end
            gbn_arq_pkg::ST_DELIV: begin
                if (push_ok) begin
                    push         = r_hold_valid;
                    n_hold_valid = 1'b1;
                    n_hold = make_result(gbn_arq_pkg::OK_DELIVER, r_in.frame_seq, '0,
                                         r_in.payload, 1'b0);
                end
            end
            gbn_arq_pkg::ST_ACK: begin
                n_acked = alu_diff;
            end
            gbn_arq_pkg::ST_ACK_APPLY: begin
                if (!too_far) begin
                    n_head  = (head_sum >= SUM_W'(BUFFER_DEPTH))
                            ? PTR_W'(head_sum - SUM_W'(BUFFER_DEPTH)) : PTR_W'(head_sum);
                    n_count = r_count - acked_cnt;
                    // A REJ rewinds to the acknowledged number as well.
                    if (past_send || r_in.frame_kind == gbn_arq_pkg::FK_REJ) begin
                        n_next = r_in.frame_seq;
                    end
                    n_unacked = r_in.frame_seq;
                end
            end
            gbn_arq_pkg::ST_WIN: begin
                buf_rd = win_open;
            end
            gbn_arq_pkg::ST_SEND: begin
                if (push_ok) begin
                    push         = r_hold_valid;
                    n_hold_valid = 1'b1;
                    n_hold = make_result(gbn_arq_pkg::OK_INFO, r_next, r_peer_addr,
                                         buf_rd_data, 1'b1);
                    n_next = seq_inc(r_next);
                end
            end
            gbn_arq_pkg::ST_FLUSH: begin
                if (r_hold_valid && slot_free) begin
                    push         = 1'b1;
                    push_last    = 1'b1;
                    n_hold_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr  <= '0;
            r_peer_addr <= gbn_arq_pkg::ADDR_W'(1);
            r_window    <= WIN_W'(7);
        end else if (i_cfg_valid && o_cfg_ready) begin
            priority case (i_cfg_index)
                gbn_arq_pkg::CFG_OWN_ADDR:  r_own_addr  <= i_cfg_data;
                gbn_arq_pkg::CFG_PEER_ADDR: r_peer_addr <= i_cfg_data;
                gbn_arq_pkg::CFG_WINDOW:    r_window    <= i_cfg_data[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gbn_arq_pkg::ST_IDLE;
            r_unacked    <= '0;
            r_next       <= '0;
            r_expected   <= '0;
            r_rej_pend   <= 1'b0;
            r_head       <= '0;
            r_count      <= '0;
            r_single     <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_unacked    <= n_unacked;
            r_next       <= n_next;
            r_expected   <= n_expected;
            r_rej_pend   <= n_rej_pend;
            r_head       <= n_head;
            r_count      <= n_count;
            r_single     <= n_single;
            r_hold_valid <= n_hold_valid;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        r_acked <= n_acked;
        r_hold  <= n_hold;
        // The last flag is the lowest bit of the result.
        if (push) begin
            r_out <= {r_hold[$bits(gbn_arq_pkg::t_out_item)-1:1], push_last};
        end
    end

`ifndef SYNTH
    // The sent-but-unacknowledged frames are always a subset of the buffered words.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUFFER_DEPTH))
        else $error("retransmit fill count beyond depth");

    a_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(gbn_arq_pkg::t_seq'(r_next - r_unacked)) <= CMP_W'(r_count))
        else $error("outstanding frames exceed buffered words");

    // No result may be left behind when the sequencer returns to idle.
    a_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbn_arq_pkg::ST_IDLE) |-> !r_hold_valid)
        else $error("result held while idle");

    // The final result of an event always leaves the sequencer in idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_last) |=> (r_state == gbn_arq_pkg::ST_IDLE))
        else $error("last result pushed before event end");
`endif

endmodule

/* hdl/gbn_arq_rtx_buf.sv */
module gbn_arq_rtx_buf #(
    parameter int BUFFER_DEPTH = gbn_arq_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic [$clog2(BUFFER_DEPTH)-1:0]    i_base,
    input  logic                               i_wr_en,
    input  logic [$clog2(BUFFER_DEPTH+1)-1:0]  i_wr_off,
    input  gbn_arq_pkg::t_data                 i_wr_data,
    input  logic                               i_rd_en,
    input  logic [$clog2(BUFFER_DEPTH+1)-1:0]  i_rd_off,
    output gbn_arq_pkg::t_data                 o_rd_data
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    gbn_arq_pkg::t_data r_mem [BUFFER_DEPTH];
    gbn_arq_pkg::t_data r_rd_data;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   rd_addr;

    // The offset never exceeds the depth, so one conditional subtract wraps the sum.
    function automatic logic [PTR_W-1:0] wrap_addr(input logic [PTR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(BUFFER_DEPTH)) begin
            sum = sum - SUM_W'(BUFFER_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign wr_addr   = wrap_addr(i_base, i_wr_off);
    assign rd_addr   = wrap_addr(i_base, i_rd_off);
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

/* bench/go_back_n_arq_link_checker.sv */
`timescale 1ns / 100ps
module go_back_n_arq_link_checker #(
    parameter int BUFFER_DEPTH = gbn_arq_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  gbn_arq_pkg::t_in_item              i_in,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  gbn_arq_pkg::t_out_item             i_out,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [gbn_arq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbn_arq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import gbn_arq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    t_addr            own_addr;
    t_addr            peer_addr;
    logic [WIN_W-1:0] win_limit;

    t_seq             unacked;
    t_seq             send_next;
    t_seq             rx_next;
    logic             rej_sent;
    t_data            retx_store [BUFFER_DEPTH];
    int               store_head;
    int               store_count;

    t_out_item        link_results_q [$];
    int               mismatches = 0;

    function automatic t_seq seq_gap(input t_seq a, input t_seq b);
        return t_seq'((int'(a) + SEQ_MODULUS - int'(b)) % SEQ_MODULUS);
    endfunction

    function automatic bit window_has_room();
        int limit;
        int outstanding;
        limit = int'(win_limit);
        if (limit > SEQ_MODULUS - 1) begin
            limit = SEQ_MODULUS - 1;
        end
        outstanding = int'(seq_gap(send_next, unacked));
        return outstanding < limit && outstanding < store_count;
    endfunction

    function automatic void expect_result(input logic [OKIND_W-1:0] kind, input t_seq seq,
                                          input t_addr dest, input t_data data,
                                          input logic timer);
        t_out_item r;
        r.out_kind      = kind;
        r.out_seq       = seq;
        r.out_dest      = dest;
        r.out_data      = data;
        r.restart_timer = timer;
        r.last          = 1'b0;
        link_results_q.push_back(r);
    endfunction

    function automatic void send_info_frame();
        int slot;
        slot = (store_head + int'(seq_gap(send_next, unacked))) % BUFFER_DEPTH;
        expect_result(OK_INFO, send_next, peer_addr, retx_store[slot], 1'b1);
        send_next = t_seq'((int'(send_next) + 1) % SEQ_MODULUS);
    endfunction

    function automatic void fill_window();
        while (window_has_room()) begin
            send_info_frame();
        end
    endfunction

    // Frees acknowledged entries; an acknowledgement beyond the stored words is refused.
    function automatic bit take_ack(input t_seq seq);
        int acked;
        int outstanding;
        acked       = int'(seq_gap(seq, unacked));
        outstanding = int'(seq_gap(send_next, unacked));
        if (acked > store_count) begin
            return 1'b0;
        end
        store_head  = (store_head + acked) % BUFFER_DEPTH;
        store_count = store_count - acked;
        if (acked > outstanding) begin
            send_next = seq;
        end
        unacked = seq;
        return 1'b1;
    endfunction

    function automatic void predict_event(input t_in_item it);
        int        first;
        t_out_item tail;
        first = link_results_q.size();
        case (it.cmd)
            CMD_APP: begin
                if (store_count < BUFFER_DEPTH) begin
                    retx_store[(store_head + store_count) % BUFFER_DEPTH] = it.payload;
                    store_count++;
                end else begin
                    expect_result(OK_DROP, '0, '0, it.payload, 1'b0);
                end
                if (window_has_room()) begin
                    send_info_frame();
                end
            end
            CMD_FRAME: begin
                if (!it.poll_bit && !it.bad_frame && it.frame_dest == own_addr) begin
                    case (it.frame_kind)
                        FK_INFO: begin
                            if (it.frame_seq != rx_next) begin
                                if (!rej_sent) begin
                                    expect_result(OK_REJ, rx_next, peer_addr, '0, 1'b0);
                                    rej_sent = 1'b1;
                                end
                            end else begin
                                rx_next  = t_seq'((int'(rx_next) + 1) % SEQ_MODULUS);
                                rej_sent = 1'b0;
                                expect_result(OK_RR, rx_next, peer_addr, '0, 1'b0);
                                expect_result(OK_DELIVER, it.frame_seq, '0, it.payload,
                                              1'b0);
                            end
                        end
                        FK_RR: begin
                            if (take_ack(it.frame_seq)) begin
                                fill_window();
                            end
                        end
                        FK_REJ: begin
                            if (take_ack(it.frame_seq)) begin
                                send_next = unacked;
                                fill_window();
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_TIMER: begin
                send_next = unacked;
                fill_window();
            end
            default: ;
        endcase
        if (link_results_q.size() > first) begin
            tail      = link_results_q.pop_back();
            tail.last = 1'b1;
            link_results_q.push_back(tail);
        end
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (link_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("unexpected result: kind %0d seq %0d dest %02h data %08h",
                         got.out_kind, got.out_seq, got.out_dest, got.out_data,
                         " timer %0b last %0b", got.restart_timer, got.last);
            end
            return;
        end
        want = link_results_q.pop_front();
        if (got.out_kind !== want.out_kind || got.out_seq !== want.out_seq ||
            got.out_dest !== want.out_dest || got.out_data !== want.out_data ||
            got.restart_timer !== want.restart_timer || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("result mismatch: expected kind %0d seq %0d dest %02h data %08h",
                         want.out_kind, want.out_seq, want.out_dest, want.out_data,
                         " timer %0b last %0b", want.restart_timer, want.last);
                $display("                 actual   kind %0d seq %0d dest %02h data %08h",
                         got.out_kind, got.out_seq, got.out_dest, got.out_data,
                         " timer %0b last %0b", got.restart_timer, got.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_addr    = '0;
            peer_addr   = 8'd1;
            win_limit   = 3'd7;
            unacked     = '0;
            send_next   = '0;
            rx_next     = '0;
            rej_sent    = 1'b0;
            store_head  = 0;
            store_count = 0;
            foreach (retx_store[i]) begin
                retx_store[i] = '0;
            end
            link_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OWN_ADDR:  own_addr  = i_cfg_data;
                    CFG_PEER_ADDR: peer_addr = i_cfg_data;
                    CFG_WINDOW:    win_limit = i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_event(i_in);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= link_results_q.size();
    end

endmodule

/* bench/go_back_n_arq_link_tb.sv */
`timescale 1ns / 100ps
module go_back_n_arq_link_tb;
    import gbn_arq_pkg::*;

    // A 12 ns clock period, so the clock toggles every 6 ns.
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    // The slowest event with no result is an acknowledgement that sends nothing,
    // and the slowest event of all sends a full window, a window check and a send step per frame.
    // This many cycles of quiet after the last result covers either with margin.
    localparam int SETTLE_CYCLES = 32;
    // Roughly 200 requests, each with at worst an idle gap, its sequencing and seven
    // results held up by stalls, plus the phase changes. The limit is taken well above that.
    localparam int CYCLE_LIMIT   = 300000;

    // Codes the block has no meaning for; they must be ignored.
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [FKIND_W-1:0]   FK_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    pending;

    // When clear, neither side inserts idle cycles.
    bit                    idle_en     = 1'b1;
    int                    stall_left  = 0;
    int                    cycle_count = 0;
    // The address the block was last told to accept, so that well-formed frames
    // reach it, and the sequence number the far end would send next in order.
    t_addr                 own_addr    = '0;
    t_seq                  peer_seq    = '0;

    always #(HALF_PERIOD) clk = ~clk;

    go_back_n_arq_link i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    go_back_n_arq_link_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The result side stalls in bursts. A burst may start on
    // any cycle, so stalls land on every stage of the block's sequencing.
    always @(posedge clk) begin
        if (idle_en && stall_left == 0 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6);
        end
        if (idle_en && stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL go_back_n_arq_link");
            $finish;
        end
    end

    // A request with every field random. The builders below override the fields
    // that matter, leaving the rest random so that every bit is toggled.
    function automatic t_in_item scramble();
        logic [63:0] noise;
        noise = {$urandom(), $urandom()};
        return noise[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item app_word(input t_data word);
        t_in_item it;
        it         = scramble();
        it.cmd     = CMD_APP;
        it.payload = word;
        return it;
    endfunction

    function automatic t_in_item timer_tick();
        t_in_item it;
        it     = scramble();
        it.cmd = CMD_TIMER;
        return it;
    endfunction

    // A clean frame addressed to the block.
    function automatic t_in_item rx_frame(input logic [FKIND_W-1:0] kind, input t_seq seq,
                                          input t_data word);
        t_in_item it;
        it            = scramble();
        it.cmd        = CMD_FRAME;
        it.frame_kind = kind;
        it.frame_seq  = seq;
        it.payload    = word;
        it.frame_dest = own_addr;
        it.poll_bit   = 1'b0;
        it.bad_frame  = 1'b0;
        return it;
    endfunction

    // The next in-order INFO frame from the far end. Only clean frames advance the
    // far end's count, as only those are taken by the block.
    function automatic t_in_item peer_info(input t_data word);
        t_in_item it;
        it       = rx_frame(FK_INFO, peer_seq, word);
        peer_seq = peer_seq + 1'b1;
        return it;
    endfunction

    // Something the block must throw away: a polled or damaged frame, a frame for
    // another address, or a command or frame kind with no meaning.
    function automatic t_in_item junk_request();
        t_in_item it;
        it = rx_frame(FK_INFO, t_seq'($urandom_range(0, 7)), $urandom());
        case ($urandom_range(0, 4))
            0: it.poll_bit = 1'b1;
            1: it.bad_frame = 1'b1;
            2: it.frame_dest = own_addr ^ t_addr'($urandom_range(1, 255));
            3: it.frame_kind = FK_UNUSED;
            default: it.cmd = CMD_UNUSED;
        endcase
        return it;
    endfunction

    // Offers one request and returns at the edge that takes it. Valid stays high
    // from one request to the next unless a gap is drawn.
    task automatic push_event(input t_in_item it);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops offering requests and waits until every predicted result has come
    // out, then lets the block finish any event that produces nothing.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes all three registers back to back. The window write carries random
    // upper bits, which the block must ignore. Optionally the unused index is
    // written too, which must change nothing.
    task automatic configure(input t_addr own, input t_addr peer, input int win,
                             input bit with_spare);
        write_reg(CFG_OWN_ADDR, own);
        write_reg(CFG_PEER_ADDR, peer);
        write_reg(CFG_WINDOW, {(CFG_DATA_W-WIN_W)'($urandom()), WIN_W'(win)});
        if (with_spare) begin
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
        end
        cfg_valid <= 1'b0;
        own_addr = own;
    endtask

    // Random traffic. Most of it is well formed, so that windows fill, frames are
    // acknowledged, rejected and resent, and the receive side runs in order; of the
    // non-application requests, 14 in 100 are discarded junk, which is not counted.
    task automatic run_traffic(input int requests, input int app_share);
        int       done;
        int       roll;
        bit       counted;
        t_in_item it;
        done = 0;
        while (done < requests) begin
            counted = 1'b1;
            if ($urandom_range(0, 99) < app_share) begin
                it = app_word($urandom());
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 30) begin
                    it = peer_info($urandom());
                end else if (roll < 40) begin
                    it = rx_frame(FK_INFO, peer_seq + t_seq'($urandom_range(1, 7)), $urandom());
                end else if (roll < 62) begin
                    it = rx_frame(FK_RR, t_seq'($urandom_range(0, 7)), $urandom());
                end else if (roll < 74) begin
                    it = rx_frame(FK_REJ, t_seq'($urandom_range(0, 7)), $urandom());
                end else if (roll < 86) begin
                    it = timer_tick();
                end else begin
                    it      = junk_request();
                    counted = 1'b0;
                end
            end
            push_event(it);
            if (counted) begin
                done++;
            end
        end
    endtask

    initial begin
        t_in_item it;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with a window of one so that the send point and the
        // acknowledgement point can be pulled apart by hand.
        configure(8'hFF, 8'h00, 1, 1'b1);
        push_event(app_word('0));
        push_event(app_word('1));
        push_event(app_word(32'h1234_5678));
        // Acknowledges beyond the one frame sent: the send point is pulled forward.
        push_event(rx_frame(FK_RR, 3'd3, $urandom()));
        // Acknowledges more words than are held: ignored.
        push_event(rx_frame(FK_RR, 3'd7, $urandom()));
        push_event(app_word(32'hA5A5_5A5A));
        push_event(timer_tick());
        push_event(rx_frame(FK_REJ, 3'd3, $urandom()));
        push_event(rx_frame(FK_RR, 3'd4, $urandom()));
        // Receive side: one in order, two out of order (only the first is
        // rejected), then in order again, which clears the reject.
        push_event(peer_info('1));
        push_event(rx_frame(FK_INFO, peer_seq + 3'd4, $urandom()));
        push_event(rx_frame(FK_INFO, peer_seq + 3'd5, $urandom()));
        push_event(peer_info('0));
        // Frames that must be discarded without a trace.
        it = rx_frame(FK_INFO, peer_seq, $urandom());
        it.poll_bit = 1'b1;
        push_event(it);
        it.poll_bit  = 1'b0;
        it.bad_frame = 1'b1;
        push_event(it);
        it.bad_frame  = 1'b0;
        it.frame_dest = ~own_addr;
        push_event(it);
        push_event(rx_frame(FK_UNUSED, peer_seq, $urandom()));
        it     = scramble();
        it.cmd = CMD_UNUSED;
        push_event(it);
        push_event(timer_tick());
        wait_quiet();

        // Widest window, mixed traffic.
        configure(8'h5A, 8'hC3, 7, 1'b0);
        run_traffic(45, 40);
        wait_quiet();

        // Mostly application words against a small window: the store fills and
        // words are dropped.
        configure(8'h3C, 8'hA5, 3, 1'b0);
        run_traffic(45, 75);
        wait_quiet();

        // A stretch at full speed on both sides.
        idle_en <= 1'b0;
        configure(8'h00, 8'hFF, 7, 1'b0);
        run_traffic(40, 45);
        wait_quiet();

        // Last phase: idling at first, then none at all to the end.
        idle_en <= 1'b1;
        configure(8'h81, 8'h7E, 2, 1'b0);
        run_traffic(20, 50);
        idle_en <= 1'b0;
        run_traffic(20, 50);
        wait_quiet();

        if (fail_count == 0 && pending == 0) begin
            $display("PASS go_back_n_arq_link");
        end else begin
            $display("FAIL go_back_n_arq_link");
        end
        $finish;
    end

endmodule

/* go_back_n_arq_link.f */
hdl/gbn_arq_pkg.sv
hdl/gbn_arq_rtx_buf.sv
hdl/go_back_n_arq_link.sv
bench/go_back_n_arq_link_checker.sv
bench/go_back_n_arq_link_tb.sv
